@@ hdl/isotp_pkg.sv @@
// Shared types and constants for the ISO-TP receive reassembler.
// Used by the decode logic, the top level and the port checker.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package isotp_pkg;

    // Largest message length that a first frame may announce.
    localparam logic [11:0] MAX_MESSAGE_LENGTH = 12'd4095;

    // Data length code limit and per-frame byte counts.
    localparam logic [3:0] DLC_MAX       = 4'd8;
    localparam logic [2:0] SF_LEN_MAX    = 3'd7;
    localparam logic [2:0] FF_DATA_BYTES = 3'd6;

    // Protocol control information types (high nibble of byte 0).
    localparam logic [3:0] FT_SINGLE = 4'h0;
    localparam logic [3:0] FT_FIRST  = 4'h1;
    localparam logic [3:0] FT_CONSEC = 4'h2;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_IGNORED  = 3'd0,
        ST_ARMED    = 3'd1,
        ST_DATA     = 3'd2,
        ST_COMPLETE = 3'd3,
        ST_SEQ_ERR  = 3'd4
    } rx_status_t;

    // Reassembly state carried from frame to frame.
    typedef struct packed {
        logic        armed;
        logic [28:0] expected_id;
        logic [28:0] reply_id;
        logic [11:0] total_length;
        logic [11:0] byte_index;
        logic [3:0]  next_sequence;
    } rx_state_t;

    // One input transaction.
    typedef struct packed {
        logic        mode;
        logic [28:0] frame_id;
        logic [28:0] flow_target_id;
        logic [3:0]  frame_length;
        logic [63:0] frame_bytes;
    } rx_item_t;

    // One result transaction.
    typedef struct packed {
        rx_status_t  status;
        logic [55:0] payload;
        logic [2:0]  payload_count;
        logic [11:0] message_length;
        logic [28:0] message_id;
        logic        send_flow;
        logic [28:0] flow_frame_id;
    } rx_result_t;

endpackage

`default_nettype wire

@@ hdl/isotp_rx_decode.sv @@
// Frame decode for the ISO-TP receiver: next reassembly state and result.
// Purely combinational; the caller registers both.
// Depends on isotp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isotp_rx_decode (
    input  wire isotp_pkg::rx_state_t st,
    input  wire isotp_pkg::rx_item_t  item,
    output isotp_pkg::rx_state_t      st_next,
    output isotp_pkg::rx_result_t     res
);

    logic [3:0]  dlc_eff;
    logic [7:0]  b0;
    logic [3:0]  ftype;
    logic [2:0]  sf_len;
    logic [11:0] ff_raw;
    logic [11:0] ff_len;
    logic [3:0]  dlc_m1;
    logic [2:0]  avail;
    logic [11:0] tot_sel;
    logic [11:0] remain;
    logic [2:0]  count;
    logic [55:0] src;
    logic [55:0] payload_m;
    logic [11:0] index_sum;
    logic        seq_match;
    logic        frame_hit;

    // Field extraction and length clamps.
    assign dlc_eff = (item.frame_length > isotp_pkg::DLC_MAX) ? isotp_pkg::DLC_MAX
                                                               : item.frame_length;
    assign b0      = item.frame_bytes[7:0];
    assign ftype   = b0[7:4];
    assign sf_len  = (b0[3:0] > {1'b0, isotp_pkg::SF_LEN_MAX}) ? isotp_pkg::SF_LEN_MAX
                                                                 : b0[2:0];
    assign ff_raw  = {b0[3:0], item.frame_bytes[15:8]};
    assign ff_len  = (ff_raw > isotp_pkg::MAX_MESSAGE_LENGTH) ? isotp_pkg::MAX_MESSAGE_LENGTH
                                                               : ff_raw;

    // Bytes the frame can carry, and bytes still owed to the message.
    assign dlc_m1  = (dlc_eff == 4'd0) ? 4'd0 : dlc_eff - 4'd1;
    assign avail   = (ftype == isotp_pkg::FT_FIRST) ? isotp_pkg::FF_DATA_BYTES : dlc_m1[2:0];
    assign tot_sel = (ftype == isotp_pkg::FT_SINGLE) ? {9'd0, sf_len} :
                     (ftype == isotp_pkg::FT_FIRST)  ? ff_len : st.total_length;
    assign remain  = (tot_sel > st.byte_index) ? tot_sel - st.byte_index : 12'd0;
    assign count   = (remain < {9'd0, avail}) ? remain[2:0] : avail;

    // Data starts at byte 2 for a first frame and at byte 1 otherwise.
    assign src = (ftype == isotp_pkg::FT_FIRST) ? {8'h00, item.frame_bytes[63:16]}
                                                : item.frame_bytes[63:8];

    // Keep only the bytes that are counted; the rest read as zero.
    always_comb
    begin
        for (int j = 0; j < 7; j++)
        begin
            payload_m[8*j +: 8] = (3'(j) < count) ? src[8*j +: 8] : 8'h00;
        end
    end

    assign index_sum = st.byte_index + {9'd0, count};
    assign seq_match = (b0[3:0] == st.next_sequence);
    assign frame_hit = st.armed && (dlc_eff != 4'd0) && (item.frame_id == st.expected_id);

    // Dispatch on arm request and frame type.
    always_comb
    begin
        st_next = st;
        res     = '0;
        priority if (item.mode)
        begin
            st_next.expected_id   = item.frame_id;
            st_next.reply_id      = item.flow_target_id;
            st_next.byte_index    = 12'd0;
            st_next.next_sequence = 4'd1;
            st_next.armed         = 1'b1;
            res.status            = isotp_pkg::ST_ARMED;
            res.message_id        = item.frame_id;
        end
        else if (frame_hit)
        begin
            unique case (ftype)
                isotp_pkg::FT_SINGLE:
                begin
                    st_next.total_length = tot_sel;
                    st_next.byte_index   = index_sum;
                    st_next.armed        = 1'b0;
                    res.status           = isotp_pkg::ST_COMPLETE;
                    res.payload          = payload_m;
                    res.payload_count    = count;
                    res.message_length   = tot_sel;
                    res.message_id       = st.expected_id;
                end
                isotp_pkg::FT_FIRST:
                begin
                    st_next.total_length = tot_sel;
                    st_next.byte_index   = index_sum;
                    res.status           = isotp_pkg::ST_DATA;
                    res.payload          = payload_m;
                    res.payload_count    = count;
                    res.message_length   = tot_sel;
                    res.message_id       = st.expected_id;
                    res.send_flow        = 1'b1;
                    res.flow_frame_id    = st.reply_id;
                end
                isotp_pkg::FT_CONSEC:
                begin
                    res.message_length = st.total_length;
                    res.message_id     = st.expected_id;
                    if (seq_match)
                    begin
                        st_next.byte_index    = index_sum;
                        st_next.next_sequence = st.next_sequence + 4'd1;
                        res.payload           = payload_m;
                        res.payload_count     = count;
                        if (index_sum == st.total_length)
                        begin
                            st_next.armed = 1'b0;
                            res.status    = isotp_pkg::ST_COMPLETE;
                        end
                        else
                        begin
                            res.status = isotp_pkg::ST_DATA;
                        end
                    end
                    else
                    begin
                        st_next.armed = 1'b0;
                        res.status    = isotp_pkg::ST_SEQ_ERR;
                    end
                end
                default:
                begin
                    // Flow-control and unknown frame types pass unnoticed.
                    st_next = st;
                    res     = '0;
                end
            endcase
        end
        else
        begin
            st_next = st;
            res     = '0;
        end
    end

endmodule

`default_nettype wire

@@ hdl/isotp_receive_reassembler_unit.sv @@
// An accepted frame's result is registered in the output slot, or in the skid entry.
// Throughput: one frame per cycle while in_stall is low; state updates at acceptance.
// An output register plus one skid entry let input continue while a result waits;
// input stalls only while the skid entry is occupied.
// Reset (rst_n low, asynchronous) disarms the receiver, sets the next sequence to 1,
// and empties both result slots.
// Top level of the ISO-TP receive reassembler; depends on isotp_pkg and isotp_rx_decode.
`timescale 1ns / 1ps
`default_nettype none

module isotp_receive_reassembler_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [28:0] frame_id,
    input  wire logic [28:0] flow_target_id,
    input  wire logic [3:0]  frame_length,
    input  wire logic [63:0] frame_bytes,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [55:0]      payload,
    output logic [2:0]       payload_count,
    output logic [11:0]      message_length,
    output logic [28:0]      message_id,
    output logic             send_flow,
    output logic [28:0]      flow_frame_id
);

    isotp_pkg::rx_state_t  state_reg;
    isotp_pkg::rx_state_t  state_next;
    isotp_pkg::rx_state_t  dec_state;
    isotp_pkg::rx_item_t   item;
    isotp_pkg::rx_result_t dec_res;
    isotp_pkg::rx_result_t out_data_reg;
    isotp_pkg::rx_result_t out_data_next;
    isotp_pkg::rx_result_t skid_data_reg;
    isotp_pkg::rx_result_t skid_data_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    logic                  accept;
    logic                  out_take;

    // Gather the input transaction.
    assign item.mode           = mode;
    assign item.frame_id       = frame_id;
    assign item.flow_target_id = flow_target_id;
    assign item.frame_length   = frame_length;
    assign item.frame_bytes    = frame_bytes;

    isotp_rx_decode u_decode (
        .st      (state_reg),
        .item    (item),
        .st_next (dec_state),
        .res     (dec_res)
    );

    // Handshake: the skid entry decides whether input can be taken.
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    // Next state of the reassembly context and the two result slots.
    always_comb
    begin
        state_next      = accept ? dec_state : state_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = dec_res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = dec_res;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            // Nothing moves; both result slots keep their contents.
            out_valid_next = out_valid_reg;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.armed         <= 1'b0;
            state_reg.expected_id   <= '0;
            state_reg.reply_id      <= '0;
            state_reg.total_length  <= '0;
            state_reg.byte_index    <= '0;
            state_reg.next_sequence <= 4'd1;
            out_valid_reg           <= 1'b0;
            skid_valid_reg          <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload registers need no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_data_reg.status;
    assign payload        = out_data_reg.payload;
    assign payload_count  = out_data_reg.payload_count;
    assign message_length = out_data_reg.message_length;
    assign message_id     = out_data_reg.message_id;
    assign send_flow      = out_data_reg.send_flow;
    assign flow_frame_id  = out_data_reg.flow_frame_id;

endmodule

`default_nettype wire

@@ hdl/isotp_checker.sv @@
// Port-level checks for the ISO-TP receive reassembler, bound to the top level.
// Depends on isotp_pkg and isotp_receive_reassembler_unit.
`timescale 1ns / 1ps
`default_nettype none

module isotp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic [55:0] payload,
    input wire logic [2:0]  payload_count,
    input wire logic [11:0] message_length,
    input wire logic [28:0] message_id,
    input wire logic        send_flow,
    input wire logic [28:0] flow_frame_id
);

    // A flow-control request only comes with a first frame, which reports data.
    a_flow_only_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_flow |-> status == isotp_pkg::ST_DATA)
        else $error("flow-control request without data status");

    // Without a flow-control request the destination ID reads as zero.
    a_flow_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_flow |-> flow_frame_id == 29'd0)
        else $error("flow frame ID set without flow request");

    // Only data and completion results carry bytes.
    a_bytes_need_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != isotp_pkg::ST_DATA && status != isotp_pkg::ST_COMPLETE
        |-> payload_count == 3'd0 && payload == 56'd0)
        else $error("bytes reported on a result without data");

    // An ignored frame reports nothing at all.
    a_ignored_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == isotp_pkg::ST_IGNORED
        |-> message_id == 29'd0 && message_length == 12'd0 && !send_flow)
        else $error("ignored frame carries result fields");

    // A stalled result stays in place.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(payload)
                                   && $stable(message_id))
        else $error("result changed while stalled");

endmodule

bind isotp_receive_reassembler_unit isotp_checker u_isotp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .payload        (payload),
    .payload_count  (payload_count),
    .message_length (message_length),
    .message_id     (message_id),
    .send_flow      (send_flow),
    .flow_frame_id  (flow_frame_id)
);

`default_nettype wire
